@@ hw/rtl/vpc_pkg.sv @@
// shared types and constants of the valve positioner controller
package vpc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int VALUE_W  = 10;
    localparam int TRIM_W   = 8;
    localparam int HYST_W   = 7;
    localparam int FAULT_W  = 6;
    localparam int LED_W    = 6;

    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic CH_SETPOINT = 1'b0;
    localparam logic CH_POSITION = 1'b1;

    // converter offset and span divisor of the calibration
    localparam int ADC_OFFSET = 186;
    localparam int SPAN_DIV   = 100;
    localparam int VALUE_MAX  = 1000;

    // divide by SPAN_DIV as multiply by reciprocal, exact for products below 2**19
    localparam int PROD_MAG_W   = 19;
    localparam int DIV100_SHIFT = 26;
    localparam int DIV100_MUL   = (2**DIV100_SHIFT + SPAN_DIV - 1) / SPAN_DIV;
    localparam int DIV100_MUL_W = 20;
    localparam int QUOT_W       = 12;

    // duty = 4*pos/5 + bias, divide by 5 exact for values below 2**12
    localparam int PWM_SHIFT = 15;
    localparam int PWM_MUL   = (2**PWM_SHIFT + 4) / 5;
    localparam int PWM_MUL_W = 13;
    localparam int PWM_BIAS  = 204;

    typedef enum logic [2:0] {
        CFG_HYSTERESIS = 3'd0,
        CFG_ANALOG     = 3'd1,
        CFG_SP_ZERO    = 3'd2,
        CFG_SP_SPAN    = 3'd3,
        CFG_POS_ZERO   = 3'd4,
        CFG_POS_SPAN   = 3'd5,
        CFG_ZERO_REF   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DRIVE_IDLE = 2'd0,
        DRIVE_FWD  = 2'd1,
        DRIVE_REV  = 2'd2
    } t_drive;

    typedef struct packed {
        logic [HYST_W-1:0] hysteresis;
        logic              analog_mode;
        logic [TRIM_W-1:0] sp_zero;
        logic [TRIM_W-1:0] sp_span;
        logic [TRIM_W-1:0] pos_zero;
        logic [TRIM_W-1:0] pos_span;
        logic [TRIM_W-1:0] zero_ref;
    } t_cfg;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        logic                remote_select;
        logic                plc_stop;
        logic                plc_forward;
        logic                plc_reverse;
        logic                switch_stop;
        logic                switch_forward;
        logic                switch_reverse;
        logic [FAULT_W-1:0]  fault_bits;
    } t_item;

    // classified word handed from front to back
    typedef struct packed {
        logic                is_tick;
        logic                cal_valid;
        logic                chan;
        logic [SAMPLE_W-1:0] avg;
        logic                remote;
        logic                cmd_stop;
        logic                cmd_fwd;
        logic                cmd_rev;
        logic [FAULT_W-1:0]  faults;
    } t_job;

    typedef struct packed {
        logic               move_forward;
        logic               move_reverse;
        logic               stopped;
        logic [VALUE_W-1:0] position_now;
        logic [VALUE_W-1:0] target_now;
        logic [VALUE_W-1:0] remote_target_now;
        logic [LED_W-1:0]   led_bits;
        logic [VALUE_W-1:0] pwm_duty;
    } t_result;

endpackage

@@ hw/rtl/valve_positioner_controller_unit.sv @@
// top level of the valve positioner controller
//
// channel  direction  handshake                 payload
// input    in         i_push / o_full           op, sample, select, commands, faults
// result   out        o_empty / i_pop           drive, latch, values, leds, duty
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word accepted per cycle while o_full is low; its result reaches the output ports through
// the front in the accept cycle, the job queue, three back stages and the result queue
// synchronous active-low reset; no clearing pass, config ready right after reset
// a stalled pop fills the 2-entry result queue, then the back stalls and the
// 4-entry job queue fills until full rises
module valve_positioner_controller_unit #(
    parameter int AVERAGE_COUNT = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [9:0]  i_sample,
    input  logic        i_remote_select,
    input  logic        i_plc_stop,
    input  logic        i_plc_forward,
    input  logic        i_plc_reverse,
    input  logic        i_switch_stop,
    input  logic        i_switch_forward,
    input  logic        i_switch_reverse,
    input  logic [5:0]  i_fault_bits,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_move_forward,
    output logic        o_move_reverse,
    output logic        o_stopped,
    output logic [9:0]  o_position_now,
    output logic [9:0]  o_target_now,
    output logic [9:0]  o_remote_target_now,
    output logic [5:0]  o_led_bits,
    output logic [9:0]  o_pwm_duty,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int JOB_W = $bits(vpc_pkg::t_job);
    localparam int RES_W = $bits(vpc_pkg::t_result);

    vpc_pkg::t_cfg    r_cfg;
    vpc_pkg::t_item   w_item;
    vpc_pkg::t_job    w_job_in;
    vpc_pkg::t_job    w_job_out;
    vpc_pkg::t_result w_res_in;
    vpc_pkg::t_result w_res_out;
    logic             w_job_push;
    logic             w_job_full;
    logic             w_job_pop;
    logic             w_job_empty;
    logic             w_res_push;
    logic             w_res_full;
    logic [JOB_W-1:0] w_job_q;
    logic [RES_W-1:0] w_res_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hysteresis  <= 7'd10;
            r_cfg.analog_mode <= 1'b0;
            r_cfg.sp_zero     <= 8'd100;
            r_cfg.sp_span     <= 8'd100;
            r_cfg.pos_zero    <= 8'd100;
            r_cfg.pos_span    <= 8'd100;
            r_cfg.zero_ref    <= 8'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                vpc_pkg::CFG_HYSTERESIS: r_cfg.hysteresis  <= i_cfg_data[6:0];
                vpc_pkg::CFG_ANALOG:     r_cfg.analog_mode <= i_cfg_data[0];
                vpc_pkg::CFG_SP_ZERO:    r_cfg.sp_zero     <= i_cfg_data;
                vpc_pkg::CFG_SP_SPAN:    r_cfg.sp_span     <= i_cfg_data;
                vpc_pkg::CFG_POS_ZERO:   r_cfg.pos_zero    <= i_cfg_data;
                vpc_pkg::CFG_POS_SPAN:   r_cfg.pos_span    <= i_cfg_data;
                vpc_pkg::CFG_ZERO_REF:   r_cfg.zero_ref    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_item.op             = i_op;
        w_item.sample         = i_sample;
        w_item.remote_select  = i_remote_select;
        w_item.plc_stop       = i_plc_stop;
        w_item.plc_forward    = i_plc_forward;
        w_item.plc_reverse    = i_plc_reverse;
        w_item.switch_stop    = i_switch_stop;
        w_item.switch_forward = i_switch_forward;
        w_item.switch_reverse = i_switch_reverse;
        w_item.fault_bits     = i_fault_bits;
    end

    assign o_full = w_job_full;

    vpc_front #(
        .AVERAGE_COUNT(AVERAGE_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (w_item),
        .i_job_full (w_job_full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    vpc_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(vpc_pkg::JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_q),
        .o_empty (w_job_empty)
    );

    assign w_job_out = w_job_q;

    vpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_job_out),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    vpc_fifo #(
        .WIDTH(RES_W),
        .DEPTH(vpc_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (w_res_q),
        .o_empty (o_empty)
    );

    assign w_res_out           = w_res_q;
    assign o_move_forward      = w_res_out.move_forward;
    assign o_move_reverse      = w_res_out.move_reverse;
    assign o_stopped           = w_res_out.stopped;
    assign o_position_now      = w_res_out.position_now;
    assign o_target_now        = w_res_out.target_now;
    assign o_remote_target_now = w_res_out.remote_target_now;
    assign o_led_bits          = w_res_out.led_bits;
    assign o_pwm_duty          = w_res_out.pwm_duty;

    // the latch always idles the motor
    a_stop_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_stopped) |-> (!o_move_forward && !o_move_reverse))
        else $error("stopped word drives the motor");

    // led bits mirror the drive and latch of the same word
    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_led_bits[0] == o_move_forward && o_led_bits[1] == o_move_reverse
                      && o_led_bits[2] == o_stopped))
        else $error("led bits disagree with drive state");

    // a pushed word reaches the result queue only after the back pipeline
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_empty) && o_empty && w_job_empty && !w_res_push) |=> o_empty)
        else $error("result appeared without a commit");

endmodule

@@ hw/rtl/vpc_fifo.sv @@
// small register queue with full and empty flags
module vpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/vpc_front.sv @@
// front end: accepts items, averages sample groups and classifies words for the back end
module vpc_front #(
    parameter int AVERAGE_COUNT = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vpc_pkg::t_item i_item,
    input  logic           i_job_full,
    output logic           o_job_push,
    output vpc_pkg::t_job  o_job
);

    localparam int SUM_W     = $clog2(AVERAGE_COUNT * (2**vpc_pkg::SAMPLE_W - 1) + 1);
    localparam int LEFT_W    = $clog2(AVERAGE_COUNT + 1);
    localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_COUNT);
    localparam int AVG_MUL   = (2**AVG_SHIFT + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
    localparam int PROD_W    = SUM_W + AVG_SHIFT + 1;

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_chan, n_chan;
    logic              w_accept;
    logic              w_is_sample;
    logic              w_group_open;
    logic [SUM_W-1:0]  w_total;
    logic [PROD_W-1:0] w_prod;

    assign w_accept     = i_push && !i_job_full;
    assign w_is_sample  = (i_item.op == vpc_pkg::OP_SAMPLE);
    assign w_group_open = (r_left > LEFT_W'(1)) && (r_left <= LEFT_W'(AVERAGE_COUNT));
    assign w_total      = r_sum + SUM_W'(i_item.sample);
    // divide by the group size through a reciprocal multiply
    assign w_prod       = PROD_W'(w_total) * PROD_W'(AVG_MUL);

    always_comb begin
        n_sum  = r_sum;
        n_left = r_left;
        n_chan = r_chan;
        if (w_accept && w_is_sample) begin
            if (w_group_open) begin
                n_sum  = w_total;
                n_left = r_left - 1'b1;
            end else begin
                n_sum  = '0;
                n_left = LEFT_W'(AVERAGE_COUNT);
                n_chan = ~r_chan;
            end
        end
    end

    always_comb begin
        o_job_push       = w_accept;
        o_job.is_tick    = (i_item.op == vpc_pkg::OP_TICK);
        o_job.cal_valid  = w_is_sample && !w_group_open;
        o_job.chan       = r_chan;
        o_job.avg        = w_prod[AVG_SHIFT +: vpc_pkg::SAMPLE_W];
        o_job.remote     = i_item.remote_select;
        o_job.cmd_stop   = i_item.remote_select ? i_item.plc_stop    : i_item.switch_stop;
        o_job.cmd_fwd    = i_item.remote_select ? i_item.plc_forward : i_item.switch_forward;
        o_job.cmd_rev    = i_item.remote_select ? i_item.plc_reverse : i_item.switch_reverse;
        o_job.faults     = i_item.fault_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_left <= LEFT_W'(AVERAGE_COUNT);
            r_chan <= vpc_pkg::CH_SETPOINT;
        end else begin
            r_sum  <= n_sum;
            r_left <= n_left;
            r_chan <= n_chan;
        end
    end

endmodule

@@ hw/rtl/vpc_back.sv @@
// back end: calibration pipeline and in-order commit of positioner state
module vpc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vpc_pkg::t_cfg    i_cfg,
    input  vpc_pkg::t_job    i_job,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output vpc_pkg::t_result o_res
);

    localparam int VW = vpc_pkg::VALUE_W;
    localparam int MAG_W = vpc_pkg::PROD_MAG_W;
    localparam int DIV_PROD_W = MAG_W + vpc_pkg::DIV100_MUL_W;
    localparam int PWM_PROD_W = VW + 2 + vpc_pkg::PWM_MUL_W;

    // pipeline valids and words
    logic r_v1, r_v2, r_v3;
    vpc_pkg::t_job r_j1, r_j2, r_j3;
    logic                        r_s1_pos;
    logic [MAG_W-1:0]            r_s1_mag;
    logic [vpc_pkg::QUOT_W-1:0]  r_s2_q;
    logic [VW-1:0]               r_s3_cal;
    logic [VW-1:0]               r_s3_pwm;

    logic                        w_adv;
    logic                        w_commit;
    logic [vpc_pkg::TRIM_W-1:0]  w_zero;
    logic [vpc_pkg::TRIM_W-1:0]  w_span;
    logic signed [11:0]          w_diff;
    logic signed [20:0]          w_prod;
    logic [DIV_PROD_W-1:0]       w_div;
    logic [VW-1:0]               w_cal;
    logic [PWM_PROD_W-1:0]       w_pwm;

    // committed state
    logic [VW-1:0]    r_pos, n_pos;
    logic [VW-1:0]    r_rtgt, n_rtgt;
    logic [VW-1:0]    r_tgt, n_tgt;
    logic [VW-1:0]    r_pwm, n_pwm;
    logic             r_latch, n_latch;
    vpc_pkg::t_drive  r_drive, n_drive;
    logic             w_auto;
    logic             w_fwd;
    logic             w_rev;
    logic [VW:0]      w_tgt_hi;
    logic [VW:0]      w_pos_hi;

    assign w_adv     = !(r_v3 && i_res_full);
    assign w_commit  = w_adv && r_v3;
    assign o_job_pop = w_adv && !i_job_empty;

    // stage 1: offset, zero trim and span multiply
    assign w_zero = (i_job.chan == vpc_pkg::CH_SETPOINT) ? i_cfg.sp_zero : i_cfg.pos_zero;
    assign w_span = (i_job.chan == vpc_pkg::CH_SETPOINT) ? i_cfg.sp_span : i_cfg.pos_span;
    assign w_diff = $signed({2'b00, i_job.avg}) - 12'sd186
                  - $signed({4'b0000, w_zero}) + $signed({4'b0000, i_cfg.zero_ref});
    assign w_prod = $signed({{9{w_diff[11]}}, w_diff}) * $signed({13'd0, w_span});

    // stage 2: divide by the span base through a reciprocal multiply
    assign w_div = DIV_PROD_W'(r_s1_mag) * DIV_PROD_W'(vpc_pkg::DIV100_MUL);

    // stage 3: clamp and duty
    always_comb begin
        if (r_s2_q <= vpc_pkg::QUOT_W'(1)) begin
            w_cal = '0;
        end else if (r_s2_q > vpc_pkg::QUOT_W'(vpc_pkg::VALUE_MAX)) begin
            w_cal = VW'(vpc_pkg::VALUE_MAX);
        end else begin
            w_cal = r_s2_q[VW-1:0];
        end
    end
    assign w_pwm = PWM_PROD_W'({w_cal, 2'b00}) * PWM_PROD_W'(vpc_pkg::PWM_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= !i_job_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j1     <= i_job;
            r_s1_pos <= (w_prod > 21'sd0);
            r_s1_mag <= w_prod[MAG_W-1:0];
            r_j2     <= r_j1;
            r_s2_q   <= r_s1_pos ? w_div[vpc_pkg::DIV100_SHIFT +: vpc_pkg::QUOT_W] : '0;
            r_j3     <= r_j2;
            r_s3_cal <= w_cal;
            r_s3_pwm <= w_pwm[vpc_pkg::PWM_SHIFT +: VW] + VW'(vpc_pkg::PWM_BIAS);
        end
    end

    // commit: ticks see every calibration committed before them
    always_comb begin
        n_pos    = r_pos;
        n_rtgt   = r_rtgt;
        n_tgt    = r_tgt;
        n_pwm    = r_pwm;
        n_latch  = r_latch;
        n_drive  = r_drive;
        w_auto   = r_j3.remote && i_cfg.analog_mode;
        w_fwd    = 1'b0;
        w_rev    = 1'b0;
        w_tgt_hi = '0;
        w_pos_hi = '0;
        if (!r_j3.is_tick) begin
            if (r_j3.cal_valid) begin
                if (r_j3.chan == vpc_pkg::CH_SETPOINT) begin
                    n_rtgt = r_s3_cal;
                end else begin
                    n_pos = r_s3_cal;
                    n_pwm = r_s3_pwm;
                end
            end
        end else begin
            if (w_auto) begin
                n_latch = 1'b0;
                n_tgt   = r_rtgt;
            end else if (r_j3.cmd_stop) begin
                n_latch = 1'b1;
            end else if (r_j3.cmd_fwd) begin
                w_fwd   = 1'b1;
                n_latch = 1'b0;
            end else if (r_j3.cmd_rev) begin
                w_rev   = 1'b1;
                n_latch = 1'b0;
            end
            if (r_j3.faults != '0) begin
                n_latch = 1'b1;
            end
            w_tgt_hi = {1'b0, n_tgt} + (VW + 1)'(i_cfg.hysteresis);
            w_pos_hi = {1'b0, r_pos} + (VW + 1)'(i_cfg.hysteresis);
            if (n_latch) begin
                n_drive = vpc_pkg::DRIVE_IDLE;
            end else if (w_auto) begin
                // hysteresis band around the remote setpoint
                if ({1'b0, r_pos} > w_tgt_hi) begin
                    n_drive = vpc_pkg::DRIVE_REV;
                end else if (w_pos_hi < {1'b0, n_tgt}) begin
                    n_drive = vpc_pkg::DRIVE_FWD;
                end else begin
                    n_drive = vpc_pkg::DRIVE_IDLE;
                end
            end else begin
                n_tgt = r_pos;
                if (w_fwd) begin
                    n_drive = vpc_pkg::DRIVE_FWD;
                end else if (w_rev) begin
                    n_drive = vpc_pkg::DRIVE_REV;
                end else begin
                    n_drive = vpc_pkg::DRIVE_IDLE;
                end
            end
        end
    end

    always_comb begin
        o_res_push              = w_commit;
        o_res.move_forward      = (n_drive == vpc_pkg::DRIVE_FWD);
        o_res.move_reverse      = (n_drive == vpc_pkg::DRIVE_REV);
        o_res.stopped           = n_latch;
        o_res.position_now      = n_pos;
        o_res.target_now        = n_tgt;
        o_res.remote_target_now = n_rtgt;
        o_res.led_bits          = {r_j3.remote, r_j3.faults[3], r_j3.faults[2], n_latch,
                                   (n_drive == vpc_pkg::DRIVE_REV),
                                   (n_drive == vpc_pkg::DRIVE_FWD)};
        o_res.pwm_duty          = n_pwm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rtgt  <= '0;
            r_tgt   <= '0;
            r_pwm   <= VW'(vpc_pkg::PWM_BIAS);
            r_latch <= 1'b0;
            r_drive <= vpc_pkg::DRIVE_IDLE;
        end else if (w_commit) begin
            r_pos   <= n_pos;
            r_rtgt  <= n_rtgt;
            r_tgt   <= n_tgt;
            r_pwm   <= n_pwm;
            r_latch <= n_latch;
            r_drive <= n_drive;
        end
    end

endmodule
